// ===== hdl/encoder_position_pd_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the encoder position PD controller
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_POSITION_PD_CONTROLLER_MACROS_SVH
`define ENCODER_POSITION_PD_CONTROLLER_MACROS_SVH

// same-cycle implication
`define ECPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ecpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpd_pkg
// Types, widths and constants shared by the PD position controller files.
// ----------------------------------------------------------------------------
package ecpd_pkg;

  localparam int FIELD_W    = 16;
  localparam int LIMIT_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int POS_W      = 32;
  localparam int ERR_W      = 33;
  localparam int FRAC_W     = 16;
  localparam int OUT_FRAC_W = 24;
  localparam int SUM_W      = 52;
  localparam int PROD_W     = ERR_W + GAIN_W + 1;
  localparam int ROUND_W    = 18;
  localparam int DIVIDEND_W = FIELD_W + ROUND_W;
  localparam int CFG_IDX_W  = 3;

  // setpoint step = round(|speed| * 2^18 / 75)
  localparam int STEP_DIVISOR = 75;
  localparam logic [ROUND_W-1:0] STEP_ROUND = ROUND_W'(37);

  localparam logic [GAIN_W-1:0]  POSITION_GAIN_RST = 16'd2048;
  localparam logic [GAIN_W-1:0]  DAMPING_GAIN_RST  = 16'd5120;
  localparam logic [GAIN_W-1:0]  VELOCITY_GAIN_RST = 16'd2560;
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST   = 15'd1500;
  localparam logic [FIELD_W-1:0] ERROR_WINDOW_RST  = 16'd300;

  localparam logic OP_INIT   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSITION_GAIN = 3'd0,
    REG_DAMPING_GAIN  = 3'd1,
    REG_VELOCITY_GAIN = 3'd2,
    REG_DRIVE_LIMIT   = 3'd3,
    REG_ERROR_WINDOW  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                      operation;
    logic [FIELD_W-1:0]        measured_count;
    logic signed [FIELD_W-1:0] speed_command;
    logic signed [FIELD_W-1:0] damping_term;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] drive;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_V,
    ST_CLIP,
    ST_FIN,
    ST_OUT
  } ecpd_state_t;

endpackage

// ===== hdl/ecpd_div_const.sv =====
// ----------------------------------------------------------------------------
// ecpd_div_const
// Bit-serial restoring divider by a fixed divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ecpd_div_const #(
  parameter int DW = ecpd_pkg::DIVIDEND_W,
  parameter int K  = ecpd_pkg::STEP_DIVISOR
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DW-1:0]        dividend,
  output ecpd_pkg::unit_stat_t stat,
  output logic [DW-1:0]        quotient
);

  localparam int RW = $clog2(K);
  localparam int CW = $clog2(DW);
  localparam logic [RW:0] KV = (RW+1)'(K);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dq_r, dq_nxt;
  logic [RW:0]   trial, trial_sub;
  logic          ge;

  // dividend bits leave at the top while quotient bits enter at the bottom
  assign trial     = {rem_r, dq_r[DW-1]};
  assign trial_sub = trial - KV;
  assign ge        = trial >= KV;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = dividend;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DW-2:0], ge};
      rem_nxt = ge ? trial_sub[RW-1:0] : trial[RW-1:0];
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

// ===== hdl/ecpd_mul_serial.sv =====
// ----------------------------------------------------------------------------
// ecpd_mul_serial
// Bit-serial signed by unsigned multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module ecpd_mul_serial #(
  parameter int AW = ecpd_pkg::ERR_W,
  parameter int BW = ecpd_pkg::GAIN_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic [BW-1:0]           b,
  output ecpd_pkg::unit_stat_t    stat,
  output logic signed [AW+BW:0]   product
);

  localparam int CW = $clog2(BW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     a_r, a_nxt;
  logic [AW:0]       hi_r, hi_nxt;
  logic [BW-1:0]     lo_r, lo_nxt;
  logic [AW:0]       addend, psum;

  // lo_r holds the unused multiplier bits; product bits shift in from the top
  assign addend = lo_r[0] ? {a_r[AW-1], a_r} : '0;
  assign psum   = hi_r + addend;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      hi_nxt   = '0;
      lo_nxt   = b;
    end else if (busy_r) begin
      hi_nxt  = {psum[AW], psum[AW:1]};
      lo_nxt  = {psum[0], lo_r[BW-1:1]};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(BW-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = {hi_r, lo_r};

endmodule

// ===== hdl/encoder_position_pd_controller.sv =====
// ----------------------------------------------------------------------------
// encoder_position_pd_controller
// PD position loop with speed feedforward on a 16.16 wrapping setpoint.
//
//   channel  dir  handshake                payload
//   in_      in   in_valid / in_ready      ecpd_pkg::in_item_t
//   out_     out  out_valid / out_ready    ecpd_pkg::out_item_t
//   cfg_     in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request at a time. An init request goes straight to the output register;
// an update runs a 34-step serial divide by 75 when the setpoint advances, then
// three passes (position, damping, speed) of one 16-step multiplier.
// A pending result sits in the output register; a new request is taken
// meanwhile and finishes only once that result has left.
// Reset is synchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "encoder_position_pd_controller_macros.svh"

module encoder_position_pd_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ecpd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ecpd_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ecpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ecpd_pkg::FIELD_W-1:0]     cfg_data
);

  localparam int FW  = ecpd_pkg::FIELD_W;
  localparam int LW  = ecpd_pkg::LIMIT_W;
  localparam int GW  = ecpd_pkg::GAIN_W;
  localparam int PW  = ecpd_pkg::POS_W;
  localparam int EW  = ecpd_pkg::ERR_W;
  localparam int FRW = ecpd_pkg::FRAC_W;
  localparam int OFW = ecpd_pkg::OUT_FRAC_W;
  localparam int SW  = ecpd_pkg::SUM_W;
  localparam int MW  = ecpd_pkg::PROD_W;
  localparam int DW  = ecpd_pkg::DIVIDEND_W;

  ecpd_pkg::ecpd_state_t state_r, state_nxt;

  logic [GW-1:0]          pgain_r, pgain_nxt;
  logic [GW-1:0]          dgain_r, dgain_nxt;
  logic [GW-1:0]          vgain_r, vgain_nxt;
  logic [LW-1:0]          lim_r, lim_nxt;
  logic [FW-1:0]          win_r, win_nxt;

  logic [PW-1:0]          setpoint_r, setpoint_nxt;
  logic signed [EW-1:0]   last_err_r, last_err_nxt;
  ecpd_pkg::in_item_t     item_r, item_nxt;
  logic signed [SW-1:0]   acc_r, acc_nxt;
  logic                   gt_r, gt_nxt;
  logic                   lt_r, lt_nxt;
  ecpd_pkg::out_item_t    res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ecpd_pkg::out_item_t    out_data_r, out_data_nxt;

  logic [EW-1:0]          err_mag;
  logic                   adv_ok;
  logic [FW-1:0]          spd_mag;
  logic [DW-1:0]          dividend, quot;
  logic [PW-1:0]          step, diff;
  logic signed [EW-1:0]   err_cur;
  logic signed [SW-1:0]   prod_ext, prod_shift, lim_scaled;
  logic [FW-1:0]          drive_trunc, lim16;

  logic                   div_start, mul_start;
  logic signed [EW-1:0]   mul_a;
  logic [GW-1:0]          mul_b;
  logic signed [MW-1:0]   prod;
  ecpd_pkg::unit_stat_t   div_stat, mul_stat;

  ecpd_div_const #(
    .DW (DW),
    .K  (ecpd_pkg::STEP_DIVISOR)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .stat     (div_stat),
    .quotient (quot)
  );

  ecpd_mul_serial #(
    .AW (EW),
    .BW (GW)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .stat    (mul_stat),
    .product (prod)
  );

  // window test on the error left by the previous update
  assign err_mag = last_err_r[EW-1] ? EW'(-last_err_r) : last_err_r;
  assign adv_ok  = err_mag < {1'b0, win_r, {FRW{1'b0}}};

  // |speed| * 2^18 + 37, rounded step comes out of the divide
  assign spd_mag  = item_r.speed_command[FW-1] ? FW'(-item_r.speed_command)
                                               : item_r.speed_command;
  assign dividend = {spd_mag, ecpd_pkg::STEP_ROUND};
  assign step     = item_r.speed_command[FW-1] ? -quot[PW-1:0] : quot[PW-1:0];

  // wrapped error; exactly half range counts as positive
  assign diff    = setpoint_r - {item_r.measured_count, {FRW{1'b0}}};
  assign err_cur = (diff == {1'b1, {(PW-1){1'b0}}}) ? {1'b0, diff} : {diff[PW-1], diff};

  assign prod_ext   = {{(SW-MW){prod[MW-1]}}, prod};
  assign prod_shift = {prod[SW-FRW-1:0], {FRW{1'b0}}};
  assign lim_scaled = {{(SW-LW-OFW){1'b0}}, lim_r, {OFW{1'b0}}};
  assign lim16      = {1'b0, lim_r};

  // truncate toward zero: floor plus one for negative sums with a fraction
  assign drive_trunc = acc_r[OFW+FW-1:OFW]
                     + {{(FW-1){1'b0}}, acc_r[SW-1] & (|acc_r[OFW-1:0])};

  always_comb begin
    state_nxt     = state_r;
    pgain_nxt     = pgain_r;
    dgain_nxt     = dgain_r;
    vgain_nxt     = vgain_r;
    lim_nxt       = lim_r;
    win_nxt       = win_r;
    setpoint_nxt  = setpoint_r;
    last_err_nxt  = last_err_r;
    item_nxt      = item_r;
    acc_nxt       = acc_r;
    gt_nxt        = gt_r;
    lt_nxt        = lt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    in_ready      = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        ecpd_pkg::REG_POSITION_GAIN: pgain_nxt = cfg_data;
        ecpd_pkg::REG_DAMPING_GAIN:  dgain_nxt = cfg_data;
        ecpd_pkg::REG_VELOCITY_GAIN: vgain_nxt = cfg_data;
        ecpd_pkg::REG_DRIVE_LIMIT:   lim_nxt   = cfg_data[LW-1:0];
        ecpd_pkg::REG_ERROR_WINDOW:  win_nxt   = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ecpd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.operation == ecpd_pkg::OP_INIT) begin
            setpoint_nxt = {in_data.measured_count, {FRW{1'b0}}};
            last_err_nxt = '0;
            res_nxt      = '0;
            state_nxt    = ecpd_pkg::ST_OUT;
          end else begin
            state_nxt = ecpd_pkg::ST_CHECK;
          end
        end
      end
      ecpd_pkg::ST_CHECK: begin
        if (adv_ok) begin
          div_start = 1'b1;
          state_nxt = ecpd_pkg::ST_DIV;
        end else begin
          state_nxt = ecpd_pkg::ST_ERR;
        end
      end
      ecpd_pkg::ST_DIV: begin
        if (div_stat.done) begin
          setpoint_nxt = setpoint_r + step;
          state_nxt    = ecpd_pkg::ST_ERR;
        end
      end
      ecpd_pkg::ST_ERR: begin
        last_err_nxt = err_cur;
        mul_start    = 1'b1;
        mul_a        = err_cur;
        mul_b        = pgain_r;
        state_nxt    = ecpd_pkg::ST_MUL_P;
      end
      ecpd_pkg::ST_MUL_P: begin
        if (mul_stat.done) begin
          acc_nxt   = prod_ext;
          mul_start = 1'b1;
          mul_a     = {{(EW-FW){item_r.damping_term[FW-1]}}, item_r.damping_term};
          mul_b     = dgain_r;
          state_nxt = ecpd_pkg::ST_MUL_D;
        end
      end
      ecpd_pkg::ST_MUL_D: begin
        if (mul_stat.done) begin
          acc_nxt   = acc_r + prod_shift;
          mul_start = 1'b1;
          mul_a     = {{(EW-FW){item_r.speed_command[FW-1]}}, item_r.speed_command};
          mul_b     = vgain_r;
          state_nxt = ecpd_pkg::ST_MUL_V;
        end
      end
      ecpd_pkg::ST_MUL_V: begin
        if (mul_stat.done) begin
          acc_nxt   = acc_r + prod_shift;
          state_nxt = ecpd_pkg::ST_CLIP;
        end
      end
      ecpd_pkg::ST_CLIP: begin
        gt_nxt    = acc_r > lim_scaled;
        lt_nxt    = acc_r < -lim_scaled;
        state_nxt = ecpd_pkg::ST_FIN;
      end
      ecpd_pkg::ST_FIN: begin
        res_nxt.drive     = gt_r ? lim16 : (lt_r ? -lim16 : drive_trunc);
        res_nxt.saturated = gt_r | lt_r;
        state_nxt         = ecpd_pkg::ST_OUT;
      end
      ecpd_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ecpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ecpd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ecpd_pkg::ST_IDLE;
      pgain_r     <= ecpd_pkg::POSITION_GAIN_RST;
      dgain_r     <= ecpd_pkg::DAMPING_GAIN_RST;
      vgain_r     <= ecpd_pkg::VELOCITY_GAIN_RST;
      lim_r       <= ecpd_pkg::DRIVE_LIMIT_RST;
      win_r       <= ecpd_pkg::ERROR_WINDOW_RST;
      setpoint_r  <= '0;
      last_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pgain_r     <= pgain_nxt;
      dgain_r     <= dgain_nxt;
      vgain_r     <= vgain_nxt;
      lim_r       <= lim_nxt;
      win_r       <= win_nxt;
      setpoint_r  <= setpoint_nxt;
      last_err_r  <= last_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    acc_r      <= acc_nxt;
    gt_r       <= gt_nxt;
    lt_r       <= lt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ECPD_ASSERT_IMP(a_ready_units_idle, in_ready, (!mul_stat.busy && !div_stat.busy), "request taken while a serial unit is busy")
  `ECPD_ASSERT_IMP(a_one_unit_busy, div_stat.busy, !mul_stat.busy, "divider and multiplier busy together")
  `ECPD_ASSERT_NXT(a_init_load, (in_valid && in_ready && (in_data.operation == ecpd_pkg::OP_INIT)), (setpoint_r == {$past(in_data.measured_count), {FRW{1'b0}}}), "init did not load the setpoint")
  `ECPD_ASSERT_IMP(a_sat_at_limit, (out_valid && out_data.saturated), ((out_data.drive == lim16) || (out_data.drive == -lim16)), "saturated drive not at the limit")

endmodule

// ===== test/tb_encoder_position_pd_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_position_pd_controller
// Self-checking bench for the PD position loop. A queue-fed driver sends init
// and update requests, and a clocked monitor checks every drive result
// against a bit-exact local model of the 16.16 setpoint, wrapped error and
// clipped sum. Gains, limit and window change between phases while the loop
// is idle. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_encoder_position_pd_controller;

  localparam int     POS_W          = ecpd_pkg::POS_W;
  localparam int     GAIN_W         = ecpd_pkg::GAIN_W;
  localparam int     LIMIT_W        = ecpd_pkg::LIMIT_W;
  localparam int     FIELD_W        = ecpd_pkg::FIELD_W;
  localparam int     CFG_IDX_W      = ecpd_pkg::CFG_IDX_W;
  localparam longint FRAC_ONE       = 64'sd65536;
  localparam longint OUT_SCALE      = 64'sd16777216;
  localparam longint HALF_RANGE     = 64'sd2147483648;
  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     NUM_PHASES     = 10;
  localparam int     ITEMS_PER_PH   = 155;
  localparam int     MAX_REPORTS    = 10;

  typedef struct {
    logic [POS_W-1:0] setpoint;
    longint           last_err;
  } loop_state_t;

  typedef struct {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  kd;
    logic [GAIN_W-1:0]  kv;
    logic [LIMIT_W-1:0] limit;
    logic [FIELD_W-1:0] window;
  } loop_gains_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  ecpd_pkg::in_item_t   in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ecpd_pkg::out_item_t  out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = ecpd_pkg::REG_POSITION_GAIN;
  logic [FIELD_W-1:0]   cfg_data  = '0;

  ecpd_pkg::in_item_t  request_q[$];
  ecpd_pkg::out_item_t drive_expect_q[$];
  loop_state_t         model_st;
  loop_state_t         plan_st;
  loop_gains_t         model_gains;
  int                  requests_planned = 0;
  int                  results_seen     = 0;
  int                  fail_count       = 0;
  int                  idle_cycles      = 0;
  int                  in_gap           = 0;
  int                  out_stall        = 0;
  bit                  in_steady        = 1'b0;
  bit                  out_steady       = 1'b0;

  encoder_position_pd_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // setpoint step in 16.16: round(|speed| * 2^18 / 75), sign reapplied
  function automatic longint setpoint_step(longint speed);
    longint mag;
    longint q;
    mag = (speed < 0) ? -speed : speed;
    q = (mag * 262144 + 37) / 75;
    return (speed < 0) ? -q : q;
  endfunction

  function automatic ecpd_pkg::out_item_t control_step(inout loop_state_t st,
                                                       input loop_gains_t g,
                                                       input ecpd_pkg::in_item_t req);
    ecpd_pkg::out_item_t res;
    logic [POS_W-1:0]    diff;
    longint              speed;
    longint              damp;
    longint              mag;
    longint              sum;
    longint              lim;
    longint              drive;
    res = '0;
    speed = longint'(req.speed_command);
    damp = longint'(req.damping_term);
    if (req.operation == ecpd_pkg::OP_INIT) begin
      st.setpoint = {req.measured_count, 16'h0000};
      st.last_err = 0;
    end else begin
      mag = (st.last_err < 0) ? -st.last_err : st.last_err;
      if (mag < longint'(g.window) * FRAC_ONE)
        st.setpoint = st.setpoint + 32'(setpoint_step(speed));
      diff = st.setpoint - {req.measured_count, 16'h0000};
      st.last_err = longint'($signed(diff));
      // exactly half range counts as positive
      if (st.last_err == -HALF_RANGE)
        st.last_err = HALF_RANGE;
      sum = longint'(g.kp) * st.last_err
          + longint'(g.kd) * damp * FRAC_ONE
          + longint'(g.kv) * speed * FRAC_ONE;
      lim = longint'(g.limit);
      if (sum > lim * OUT_SCALE) begin
        drive = lim;
        res.saturated = 1'b1;
      end else if (sum < -lim * OUT_SCALE) begin
        drive = -lim;
        res.saturated = 1'b1;
      end else begin
        drive = sum / OUT_SCALE;
      end
      res.drive = 16'(drive);
    end
    return res;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(1, 1024));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // full 16-bit data so the masked top bit gets exercised too
  function automatic logic [FIELD_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'h7fff;
      2:       return FIELD_W'($urandom_range(1, 3000));
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_window();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 16'h8000;
      2:       return 16'hffff;
      3:       return FIELD_W'($urandom_range(1, 2000));
      default: return FIELD_W'($urandom_range(2001, 40000));
    endcase
  endfunction

  function automatic int pick_speed();
    case ($urandom_range(0, 4))
      0:       return int'($urandom_range(0, 400)) - 200;
      1:       return int'($urandom_range(0, 4000)) - 2000;
      2:       return $urandom_range(0, 1) ? 32767 : -32768;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic int pick_damping();
    case ($urandom_range(0, 4))
      0:       return int'($urandom_range(0, 100)) - 50;
      1:       return 0;
      2:       return $urandom_range(0, 1) ? 32767 : -32768;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s", msg);
  endtask

  // plan_st tracks the loop so tracking requests can land near the setpoint
  task automatic add_request(input logic op, input int meas, input int speed,
                             input int damp);
    ecpd_pkg::in_item_t  req;
    ecpd_pkg::out_item_t unused;
    req.operation      = op;
    req.measured_count = 16'(meas);
    req.speed_command  = 16'(speed);
    req.damping_term   = 16'(damp);
    unused = control_step(plan_st, model_gains, req);
    request_q.push_back(req);
    requests_planned++;
  endtask

  task automatic add_random_request();
    int r;
    int speed;
    int noise;
    int meas;
    r = $urandom_range(0, 99);
    speed = pick_speed();
    case ($urandom_range(0, 3))
      0:       noise = 2;
      1:       noise = 100;
      2:       noise = 600;
      default: noise = 5000;
    endcase
    if (r < 6) begin
      add_request(ecpd_pkg::OP_INIT, int'($urandom_range(0, 65535)), speed, pick_damping());
    end else if (r < 85) begin
      meas = int'(plan_st.setpoint[31:16]) + (speed * 4) / 75
           + int'($urandom_range(0, 2 * noise)) - noise;
      add_request(ecpd_pkg::OP_UPDATE, meas, speed, pick_damping());
    end else begin
      add_request(ecpd_pkg::OP_UPDATE, int'($urandom_range(0, 65535)), speed,
                  pick_damping());
    end
  endtask

  // called at a clock edge; returns at the edge where the write is taken
  task automatic write_reg(input ecpd_pkg::cfg_reg_t idx, input logic [FIELD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ecpd_pkg::REG_POSITION_GAIN: model_gains.kp     = val;
      ecpd_pkg::REG_DAMPING_GAIN:  model_gains.kd     = val;
      ecpd_pkg::REG_VELOCITY_GAIN: model_gains.kv     = val;
      ecpd_pkg::REG_DRIVE_LIMIT:   model_gains.limit  = val[LIMIT_W-1:0];
      ecpd_pkg::REG_ERROR_WINDOW:  model_gains.window = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (results_seen != requests_planned || drive_expect_q.size() != 0);
  endtask

  always @(posedge clk) begin : driver
    ecpd_pkg::out_item_t predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = control_step(model_st, model_gains, in_data);
        drive_expect_q.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (request_q.size() != 0) begin
          in_data  <= request_q.pop_front();
          in_valid <= 1'b1;
          in_gap = in_steady ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    ecpd_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (drive_expect_q.size() == 0) begin
          report_failure($sformatf("result %0d with no request pending: drive %0d sat %0b",
                                   results_seen, out_data.drive, out_data.saturated));
        end else begin
          want = drive_expect_q.pop_front();
          if (out_data.drive !== want.drive || out_data.saturated !== want.saturated)
            report_failure($sformatf(
              "mismatch on result %0d: drive exp %0d got %0d, saturated exp %0b got %0b",
              results_seen, want.drive, out_data.drive, want.saturated,
              out_data.saturated));
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
        if (!out_steady && $urandom_range(0, 4) == 0)
          out_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : sequencer
    model_st.setpoint   = '0;
    model_st.last_err   = 0;
    plan_st             = model_st;
    model_gains.kp      = ecpd_pkg::POSITION_GAIN_RST;
    model_gains.kd      = ecpd_pkg::DAMPING_GAIN_RST;
    model_gains.kv      = ecpd_pkg::VELOCITY_GAIN_RST;
    model_gains.limit   = ecpd_pkg::DRIVE_LIMIT_RST;
    model_gains.window  = ecpd_pkg::ERROR_WINDOW_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        // reset gains; updates before any init run from the cleared state
        add_request(ecpd_pkg::OP_UPDATE, 0, 0, 0);
        add_request(ecpd_pkg::OP_UPDATE, 65535, 32767, -32768);
        add_request(ecpd_pkg::OP_INIT, 0, -32768, 32767);
        // half-range error counts as positive
        add_request(ecpd_pkg::OP_UPDATE, 32768, 0, 0);
        add_request(ecpd_pkg::OP_UPDATE, 0, 100, 0);
        add_request(ecpd_pkg::OP_INIT, 65535, 0, 0);
        add_request(ecpd_pkg::OP_UPDATE, 65535, 32767, 32767);
        add_request(ecpd_pkg::OP_UPDATE, 0, -32768, -32768);
        add_request(ecpd_pkg::OP_INIT, 32768, 0, 0);
        add_request(ecpd_pkg::OP_UPDATE, 0, 0, 0);
        add_request(ecpd_pkg::OP_INIT, 12345, 0, 0);
        add_request(ecpd_pkg::OP_UPDATE, 12345, 0, 0);
        add_request(ecpd_pkg::OP_UPDATE, 12345, 1, 1);
        add_request(ecpd_pkg::OP_UPDATE, 12345, -1, -1);
        add_request(ecpd_pkg::OP_UPDATE, 12346, 3, 0);
        add_request(ecpd_pkg::OP_INIT, 0, 0, 0);
        add_request(ecpd_pkg::OP_UPDATE, 65535, 0, 0);
        add_request(ecpd_pkg::OP_UPDATE, 1, 0, 0);
        add_request(ecpd_pkg::OP_UPDATE, 0, 0, 32767);
        add_request(ecpd_pkg::OP_UPDATE, 0, 0, -32768);
        add_request(ecpd_pkg::OP_INIT, 40000, 1000, -1000);
        add_request(ecpd_pkg::OP_UPDATE, 40050, 1000, 0);
      end else begin
        wait_drained();
        case (ph)
          1: begin
            write_reg(ecpd_pkg::REG_POSITION_GAIN, 16'hffff);
            write_reg(ecpd_pkg::REG_DAMPING_GAIN, 16'hffff);
            write_reg(ecpd_pkg::REG_VELOCITY_GAIN, 16'hffff);
            write_reg(ecpd_pkg::REG_DRIVE_LIMIT, 16'h7fff);
            write_reg(ecpd_pkg::REG_ERROR_WINDOW, 16'hffff);
          end
          2: begin
            write_reg(ecpd_pkg::REG_POSITION_GAIN, 16'h0000);
            write_reg(ecpd_pkg::REG_DAMPING_GAIN, 16'h0000);
            write_reg(ecpd_pkg::REG_VELOCITY_GAIN, 16'h0000);
            write_reg(ecpd_pkg::REG_DRIVE_LIMIT, 16'h0000);
            write_reg(ecpd_pkg::REG_ERROR_WINDOW, 16'h0000);
          end
          3: begin
            // zero limit with live gains: drive stays 0, flag follows the sum
            write_reg(ecpd_pkg::REG_POSITION_GAIN, ecpd_pkg::POSITION_GAIN_RST);
            write_reg(ecpd_pkg::REG_DAMPING_GAIN, pick_gain());
            write_reg(ecpd_pkg::REG_VELOCITY_GAIN, pick_gain());
            write_reg(ecpd_pkg::REG_DRIVE_LIMIT, 16'h0000);
            write_reg(ecpd_pkg::REG_ERROR_WINDOW, 16'h8000);
          end
          4: begin
            // zero window: setpoint frozen
            write_reg(ecpd_pkg::REG_POSITION_GAIN, pick_gain());
            write_reg(ecpd_pkg::REG_DAMPING_GAIN, pick_gain());
            write_reg(ecpd_pkg::REG_VELOCITY_GAIN, pick_gain());
            write_reg(ecpd_pkg::REG_DRIVE_LIMIT, 16'($urandom_range(1, 32767)));
            write_reg(ecpd_pkg::REG_ERROR_WINDOW, 16'h0000);
          end
          default: begin
            write_reg(ecpd_pkg::REG_POSITION_GAIN, pick_gain());
            write_reg(ecpd_pkg::REG_DAMPING_GAIN, pick_gain());
            write_reg(ecpd_pkg::REG_VELOCITY_GAIN, pick_gain());
            write_reg(ecpd_pkg::REG_DRIVE_LIMIT, pick_limit());
            write_reg(ecpd_pkg::REG_ERROR_WINDOW, pick_window());
          end
        endcase
        cfg_valid <= 1'b0;
      end
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PH; n++)
        add_random_request();
    end

    wait_drained();
    repeat (120) @(posedge clk);
    if (fail_count == 0 && drive_expect_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
